// ===== design/sacl_pkg.sv =====
package sacl_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPLIT,
    S_META,
    S_TAG_RD,
    S_TAG_CMP,
    S_MISS
  } state_t;

  // configuration register indexes
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_SET_INDEX_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS_IN_USE    = 2'd2;

  localparam int SET_BITS_W = 3;
  localparam int OFFSET_W   = 4;
  localparam int WAYS_W     = 4;

  localparam int IN_ADDR_W = 64;
  localparam int CNT_W     = 32;
  localparam int WAY_OUT_W = 3;
  // offset plus set bits stays below 32
  localparam int SHAMT_W   = 5;

endpackage

// ===== design/set_assoc_cache_tag_lookup.sv =====
// a lookup splits the address, reads the set state, then reads and compares one way at a time:
// a hit in way k ends after ways 0 .. k, a miss after the n valid lines (n <= ways in use)
// one tag comparator and a single-read-port tag ram, so each way is read, then compared
// busy is high until the result cycle, so the next word may start with the strobe
// the result is shown for one cycle only, the receiver cannot stall
// synchronous reset: all lines invalid, fill pointers and counters zero, registers default
module set_assoc_cache_tag_lookup #(
  parameter int MAX_SETS   = 64,
  parameter int MAX_WAYS   = 8,
  parameter int ADDR_WIDTH = 64
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [sacl_pkg::IN_ADDR_W-1:0]        in_address,
  input  logic                                  cfg_we,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  output logic                                  out_valid,
  output logic                                  out_hit,
  output logic                                  out_evicted,
  output logic [sacl_pkg::WAY_OUT_W-1:0]        out_way,
  output logic [sacl_pkg::CNT_W-1:0]            out_hit_count,
  output logic [sacl_pkg::CNT_W-1:0]            out_miss_count,
  output logic [sacl_pkg::CNT_W-1:0]            out_eviction_count
);

  localparam int SET_AW    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int SBITS_MAX = $clog2(MAX_SETS + 1) - 1;
  localparam int WAY_AW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
  localparam int TAG_DEPTH = MAX_SETS * MAX_WAYS;
  localparam int TAG_AW    = (TAG_DEPTH > 1) ? $clog2(TAG_DEPTH) : 1;
  localparam int META_W    = WCNT_W + WAY_AW;

  sacl_pkg::state_t state_r, state_nxt;

  logic [sacl_pkg::SET_BITS_W-1:0] set_index_bits_r;
  logic [sacl_pkg::OFFSET_W-1:0]   offset_bits_r;
  logic [sacl_pkg::WAYS_W-1:0]     ways_in_use_r;

  logic [ADDR_WIDTH-1:0] addr_r;
  logic [ADDR_WIDTH-1:0] tag_r;
  logic [SET_AW-1:0]     set_r;
  logic [WCNT_W-1:0]     cnt_r;
  logic [WAY_AW-1:0]     ptr_r;
  logic [WCNT_W-1:0]     limit_r;
  logic [WAY_AW-1:0]     way_r;
  logic [MAX_SETS-1:0]   set_vld_r;
  logic                  meta_rvld_r;

  logic [sacl_pkg::CNT_W-1:0] hit_cnt_r, miss_cnt_r, evict_cnt_r;
  logic                           out_valid_r, out_hit_r, out_evicted_r;
  logic [sacl_pkg::WAY_OUT_W-1:0] out_way_r;

  logic [3:0]                     sbits_eff;
  logic [4:0]                     ways_wide;
  logic [4:0]                     ways_clamp;
  logic [WCNT_W-1:0]              ways_eff;
  logic [ADDR_WIDTH-1:0]          offset_shift;
  logic [SET_AW-1:0]              set_mask;
  logic [SET_AW-1:0]              set_calc;
  logic [sacl_pkg::SHAMT_W-1:0]   tag_shamt;
  logic [ADDR_WIDTH-1:0]          tag_calc;

  logic [META_W-1:0]     meta_rdata, meta_wdata;
  logic [WCNT_W-1:0]     meta_cnt;
  logic [WAY_AW-1:0]     meta_ptr;
  logic [WCNT_W-1:0]     limit_calc;
  logic [ADDR_WIDTH-1:0] tag_rdata;
  logic [TAG_AW-1:0]     tag_raddr, tag_waddr;
  logic                  tag_hit;
  logic [WCNT_W-1:0]     way_inc;

  logic                  fill;
  logic [WAY_AW-1:0]     victim;
  logic [WCNT_W-1:0]     victim_inc;
  logic [WAY_AW-1:0]     ptr_adv;
  logic [WAY_AW-1:0]     miss_way;
  logic                  done_hit, do_miss;

  // effective geometry
  always_comb begin
    sbits_eff = ({1'b0, set_index_bits_r} < 4'(SBITS_MAX)) ? {1'b0, set_index_bits_r}
                                                          : 4'(SBITS_MAX);
    ways_wide = {1'b0, ways_in_use_r};
    if (ways_wide == 5'd0) begin
      ways_clamp = 5'd1;
    end else if (ways_wide > 5'(MAX_WAYS)) begin
      ways_clamp = 5'(MAX_WAYS);
    end else begin
      ways_clamp = ways_wide;
    end
    ways_eff = WCNT_W'(ways_clamp);
  end

  // address split
  assign offset_shift = addr_r >> offset_bits_r;
  assign set_mask     = ~({SET_AW{1'b1}} << sbits_eff);
  assign set_calc     = offset_shift[SET_AW-1:0] & set_mask;
  assign tag_shamt    = sacl_pkg::SHAMT_W'(offset_bits_r) + sacl_pkg::SHAMT_W'(sbits_eff);
  assign tag_calc     = addr_r >> tag_shamt;

  // set state: fill count and fill pointer, zero until the set is first written
  assign meta_cnt   = meta_rvld_r ? meta_rdata[META_W-1 -: WCNT_W] : '0;
  assign meta_ptr   = meta_rvld_r ? meta_rdata[WAY_AW-1:0] : '0;
  assign limit_calc = (meta_cnt < ways_eff) ? meta_cnt : ways_eff;

  assign tag_hit = (tag_rdata == tag_r);
  assign way_inc = WCNT_W'(way_r) + WCNT_W'(1);

  // ways fill in order, so the valid lines of a set are always ways 0 .. cnt-1
  always_comb begin
    fill       = (cnt_r < ways_eff);
    victim     = (WCNT_W'(ptr_r) < ways_eff) ? ptr_r : '0;
    victim_inc = WCNT_W'(victim) + WCNT_W'(1);
    ptr_adv    = (victim_inc >= ways_eff) ? '0 : victim_inc[WAY_AW-1:0];
    miss_way   = fill ? cnt_r[WAY_AW-1:0] : victim;
    meta_wdata = fill ? {cnt_r + WCNT_W'(1), ptr_r} : {cnt_r, ptr_adv};
  end

  assign tag_raddr = TAG_AW'(set_r * MAX_WAYS + way_r);
  assign tag_waddr = TAG_AW'(set_r * MAX_WAYS + miss_way);

  sacl_ram #(
    .WIDTH (ADDR_WIDTH),
    .DEPTH (TAG_DEPTH)
  ) u_tag_ram (
    .clk   (clk),
    .we    (do_miss),
    .waddr (tag_waddr),
    .wdata (tag_r),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  sacl_ram #(
    .WIDTH (META_W),
    .DEPTH (MAX_SETS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (do_miss),
    .waddr (set_r),
    .wdata (meta_wdata),
    .raddr (set_calc),
    .rdata (meta_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sacl_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    done_hit  = 1'b0;
    do_miss   = 1'b0;
    unique case (state_r)
      sacl_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = sacl_pkg::S_SPLIT;
        end
      end
      sacl_pkg::S_SPLIT: begin
        state_nxt = sacl_pkg::S_META;
      end
      sacl_pkg::S_META: begin
        state_nxt = (limit_calc == '0) ? sacl_pkg::S_MISS : sacl_pkg::S_TAG_RD;
      end
      sacl_pkg::S_TAG_RD: begin
        state_nxt = sacl_pkg::S_TAG_CMP;
      end
      sacl_pkg::S_TAG_CMP: begin
        if (tag_hit) begin
          done_hit  = 1'b1;
          state_nxt = sacl_pkg::S_IDLE;
        end else if (way_inc < limit_r) begin
          state_nxt = sacl_pkg::S_TAG_RD;
        end else begin
          state_nxt = sacl_pkg::S_MISS;
        end
      end
      sacl_pkg::S_MISS: begin
        do_miss   = 1'b1;
        state_nxt = sacl_pkg::S_IDLE;
      end
      default: begin
        state_nxt = sacl_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != sacl_pkg::S_IDLE);

  // datapath
  always_ff @(posedge clk) begin
    if (state_r == sacl_pkg::S_IDLE && start) begin
      addr_r <= in_address[ADDR_WIDTH-1:0];
    end
    if (state_r == sacl_pkg::S_SPLIT) begin
      set_r <= set_calc;
      tag_r <= tag_calc;
    end
    if (state_r == sacl_pkg::S_META) begin
      cnt_r   <= meta_cnt;
      ptr_r   <= meta_ptr;
      limit_r <= limit_calc;
      way_r   <= '0;
    end
    if (state_r == sacl_pkg::S_TAG_CMP && !tag_hit) begin
      way_r <= way_r + WAY_AW'(1);
    end
    if (done_hit) begin
      out_hit_r     <= 1'b1;
      out_evicted_r <= 1'b0;
      out_way_r     <= sacl_pkg::WAY_OUT_W'(way_r);
    end
    if (do_miss) begin
      out_hit_r     <= 1'b0;
      out_evicted_r <= !fill;
      out_way_r     <= sacl_pkg::WAY_OUT_W'(miss_way);
    end
  end

  // control state and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_index_bits_r <= sacl_pkg::SET_BITS_W'(1);
      offset_bits_r    <= sacl_pkg::OFFSET_W'(2);
      ways_in_use_r    <= sacl_pkg::WAYS_W'(2);
      set_vld_r        <= '0;
      meta_rvld_r      <= 1'b0;
      hit_cnt_r        <= '0;
      miss_cnt_r       <= '0;
      evict_cnt_r      <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sacl_pkg::REG_SET_INDEX_BITS: set_index_bits_r <= cfg_wdata[sacl_pkg::SET_BITS_W-1:0];
          sacl_pkg::REG_OFFSET_BITS:    offset_bits_r    <= cfg_wdata[sacl_pkg::OFFSET_W-1:0];
          sacl_pkg::REG_WAYS_IN_USE:    ways_in_use_r    <= cfg_wdata[sacl_pkg::WAYS_W-1:0];
          default: begin
          end
        endcase
      end
      meta_rvld_r <= set_vld_r[set_calc];
      out_valid_r <= done_hit || do_miss;
      if (done_hit && hit_cnt_r != '1) begin
        hit_cnt_r <= hit_cnt_r + sacl_pkg::CNT_W'(1);
      end
      if (do_miss) begin
        set_vld_r[set_r] <= 1'b1;
        if (miss_cnt_r != '1) begin
          miss_cnt_r <= miss_cnt_r + sacl_pkg::CNT_W'(1);
        end
        if (!fill && evict_cnt_r != '1) begin
          evict_cnt_r <= evict_cnt_r + sacl_pkg::CNT_W'(1);
        end
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_hit            = out_hit_r;
  assign out_evicted        = out_evicted_r;
  assign out_way            = out_way_r;
  assign out_hit_count      = hit_cnt_r;
  assign out_miss_count     = miss_cnt_r;
  assign out_eviction_count = evict_cnt_r;

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_evicted_r |-> !out_hit_r)
    else $error("eviction flagged on a hit");

  a_counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !out_valid_r |->
      $stable(hit_cnt_r) && $stable(miss_cnt_r) && $stable(evict_cnt_r))
    else $error("counter moved without a result word");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sacl_pkg::S_TAG_CMP |-> WCNT_W'(way_r) < limit_r)
    else $error("tag compare beyond the valid ways of the set");

endmodule

// ===== design/sacl_ram.sv =====
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== tb/tb_top.sv =====
typedef struct packed {
  logic        hit;
  logic        evicted;
  logic [2:0]  way;
  logic [31:0] hit_count;
  logic [31:0] miss_count;
  logic [31:0] eviction_count;
} lookup_t;

class lookup_checker;
  localparam int SETS     = 64;
  localparam int WAYS     = 8;
  localparam int SET_LOG2 = $clog2(SETS);

  logic [sacl_pkg::SET_BITS_W-1:0] set_bits_r;
  logic [sacl_pkg::OFFSET_W-1:0]   offset_r;
  logic [sacl_pkg::WAYS_W-1:0]     ways_r;

  bit          line_valid [SETS*WAYS];
  logic [63:0] line_tag   [SETS*WAYS];
  logic [2:0]  fill_ptr   [SETS];
  logic [31:0] hits, misses, evictions;

  lookup_t pending_lookups [$];
  int      errors;

  function new();
    set_bits_r = 3'd1;
    offset_r   = 4'd2;
    ways_r     = 4'd2;
    foreach (line_valid[i]) line_valid[i] = 0;
    foreach (fill_ptr[i]) fill_ptr[i] = '0;
    hits      = '0;
    misses    = '0;
    evictions = '0;
    errors    = 0;
  endfunction

  function void write_reg(logic [sacl_pkg::CFG_IDX_W-1:0] idx,
                          logic [sacl_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      sacl_pkg::REG_SET_INDEX_BITS: set_bits_r = data[sacl_pkg::SET_BITS_W-1:0];
      sacl_pkg::REG_OFFSET_BITS:    offset_r   = data[sacl_pkg::OFFSET_W-1:0];
      sacl_pkg::REG_WAYS_IN_USE:    ways_r     = data[sacl_pkg::WAYS_W-1:0];
      default: ;
    endcase
  endfunction

  function int set_bits_used();
    return (set_bits_r < SET_LOG2) ? int'(set_bits_r) : SET_LOG2;
  endfunction

  // bits below the tag: offset plus set index
  function int index_low_bits();
    return int'(offset_r) + set_bits_used();
  endfunction

  function int pending();
    return pending_lookups.size();
  endfunction

  function logic [31:0] sat_inc(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  function void note_address(logic [63:0] addr);
    int          sbits, nways, set_no, base, w;
    logic [63:0] tag;
    lookup_t     r;
    bit          found;
    sbits  = set_bits_used();
    nways  = (ways_r == 0) ? 1 : ((ways_r > WAYS) ? WAYS : int'(ways_r));
    set_no = int'((addr >> offset_r) & ((64'd1 << sbits) - 64'd1));
    tag    = addr >> index_low_bits();
    base   = set_no * WAYS;
    r      = '0;
    found  = 0;
    for (w = 0; w < nways; w++) begin
      if (line_valid[base+w] && line_tag[base+w] == tag) begin
        r.hit = 1;
        r.way = w[2:0];
        break;
      end
    end
    if (r.hit) begin
      hits = sat_inc(hits);
    end else begin
      misses = sat_inc(misses);
      // empty ways fill first, lowest way number wins
      for (w = 0; w < nways; w++) begin
        if (!line_valid[base+w]) begin
          r.way = w[2:0];
          found = 1;
          break;
        end
      end
      if (!found) begin
        w = int'(fill_ptr[set_no]);
        if (w >= nways) w = 0;
        fill_ptr[set_no] = (w + 1 >= nways) ? 3'd0 : 3'(w + 1);
        r.way     = w[2:0];
        r.evicted = 1;
        evictions = sat_inc(evictions);
      end
      line_valid[base+int'(r.way)] = 1;
      line_tag[base+int'(r.way)]   = tag;
    end
    r.hit_count      = hits;
    r.miss_count     = misses;
    r.eviction_count = evictions;
    pending_lookups.push_back(r);
  endfunction

  function void compare_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  function void check_lookup(lookup_t got);
    lookup_t want;
    if (pending_lookups.size() == 0) begin
      $error("result word with no lookup outstanding");
      errors++;
      return;
    end
    want = pending_lookups.pop_front();
    compare_field("hit", want.hit, got.hit);
    compare_field("evicted", want.evicted, got.evicted);
    compare_field("way", want.way, got.way);
    compare_field("hit_count", want.hit_count, got.hit_count);
    compare_field("miss_count", want.miss_count, got.miss_count);
    compare_field("eviction_count", want.eviction_count, got.eviction_count);
  endfunction
endclass

module tb_top;
  localparam logic [sacl_pkg::CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  logic                            clk = 0;
  logic                            rst_n = 0;
  logic                            start = 0;
  logic                            busy;
  logic [sacl_pkg::IN_ADDR_W-1:0]  in_address = '0;
  logic                            cfg_we = 0;
  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                            out_valid;
  logic                            out_hit;
  logic                            out_evicted;
  logic [sacl_pkg::WAY_OUT_W-1:0]  out_way;
  logic [sacl_pkg::CNT_W-1:0]      out_hit_count;
  logic [sacl_pkg::CNT_W-1:0]      out_miss_count;
  logic [sacl_pkg::CNT_W-1:0]      out_eviction_count;

  lookup_checker scb;

  set_assoc_cache_tag_lookup dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_address         (in_address),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_hit            (out_hit),
    .out_evicted        (out_evicted),
    .out_way            (out_way),
    .out_hit_count      (out_hit_count),
    .out_miss_count     (out_miss_count),
    .out_eviction_count (out_eviction_count)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      scb.check_lookup(lookup_t'({out_hit, out_evicted, out_way, out_hit_count,
                                  out_miss_count, out_eviction_count}));
    end
  end

  // called right after a rising edge, returns right after one
  task automatic write_reg(logic [sacl_pkg::CFG_IDX_W-1:0] idx,
                           logic [sacl_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    scb.write_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [3:0] sbits, logic [3:0] offs, logic [3:0] nways);
    write_reg(sacl_pkg::REG_SET_INDEX_BITS, sbits);
    write_reg(sacl_pkg::REG_OFFSET_BITS, offs);
    write_reg(sacl_pkg::REG_WAYS_IN_USE, nways);
  endtask

  task automatic send_words(input logic [63:0] words [$], input bit no_gaps);
    int gap;
    foreach (words[i]) begin
      in_address <= words[i];
      start      <= 1'b1;
      do @(posedge clk); while (busy);
      scb.note_address(words[i]);
      gap = no_gaps ? 0 : $urandom_range(0, 10);
      // keep start high straight into the next word when there is no gap
      if (gap > 0 || i == words.size() - 1) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_lookups();
    int guard;
    guard = 0;
    while (scb.pending() != 0 && guard < 2000) begin
      @(negedge clk);
      guard++;
    end
    @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // mostly revisits of a small pool of lines, some conflicting tags, some noise
  task automatic run_lookups(int count, int pool_n, bit no_gaps);
    logic [63:0] pool [$];
    logic [63:0] words [$];
    logic [63:0] a, keep, offs_mask;
    int          k, roll;
    for (int i = 0; i < pool_n; i++) pool.push_back({$urandom, $urandom});
    keep      = (64'd1 << scb.index_low_bits()) - 64'd1;
    offs_mask = (64'd1 << scb.offset_r) - 64'd1;
    for (int i = 0; i < count; i++) begin
      k    = $urandom_range(0, pool_n - 1);
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        a = pool[k] ^ ({$urandom, $urandom} & offs_mask);
      end else if (roll < 85) begin
        // same set, fresh tag
        a = ({$urandom, $urandom} & ~keep) | (pool[k] & keep);
        if ($urandom_range(0, 1) == 1) pool[k] = a;
      end else begin
        a = {$urandom, $urandom};
      end
      words.push_back(a);
    end
    send_words(words, no_gaps);
  endtask

  initial begin
    logic [63:0] directed [$];
    scb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset config: one set bit, 4-byte blocks, two ways
    directed = '{64'h0, 64'h3, 64'h8, 64'h10, 64'h0, 64'h4,
                 64'hFFFF_FFFF_FFFF_FFFF, 64'hAAAA_AAAA_AAAA_AAAA,
                 64'h5555_5555_5555_5555, 64'h8000_0000_0000_0000,
                 64'hFFFF_FFFF_FFFF_FFFC, 64'h10, 64'h7FFF_FFFF_FFFF_FFFF,
                 64'h13, 64'h0};
    send_words(directed, 0);
    drain_lookups();

    set_config(4'd0, 4'd0, 4'd1);
    run_lookups(80, 6, 1);
    drain_lookups();

    set_config(4'd6, 4'd12, 4'd8);
    run_lookups(100, 24, 0);
    drain_lookups();

    // fewer ways leaves fill pointers past the end
    set_config(4'd6, 4'd12, 4'd3);
    run_lookups(60, 16, 1);
    drain_lookups();

    set_config(4'd7, 4'd15, 4'd15);
    run_lookups(80, 20, 0);
    drain_lookups();

    set_config(4'd3, 4'd4, 4'd0);
    write_reg(REG_UNMAPPED, 4'hF);
    run_lookups(60, 10, 0);
    drain_lookups();

    // upper data bit dropped for the set bits register
    set_config(4'hA, 4'd5, 4'd4);
    run_lookups(80, 12, 1);
    drain_lookups();

    set_config(4'd5, 4'd1, 4'd6);
    run_lookups(90, 20, 0);
    drain_lookups();

    set_config(4'hC, 4'd3, 4'd9);
    run_lookups(85, 10, 0);
    drain_lookups();

    repeat (25) @(posedge clk);
    if (scb.pending() != 0) begin
      $error("%0d lookup results never arrived", scb.pending());
      scb.errors++;
    end
    if (scb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end
endmodule

// ===== sim.f =====
design/sacl_pkg.sv
design/sacl_ram.sv
design/set_assoc_cache_tag_lookup.sv
tb/tb_top.sv
